[design/utu_pkg.sv]
// Shared types and constants of the UTF-8 to UTF-16LE transcoder.
`timescale 1ns / 1ps
`default_nettype none

package utu_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_LEAD   = 2'd1,
      ST_INCOMPLETE = 2'd2,
      ST_TOO_LARGE  = 2'd3
   } status_type;

   // Input word
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_final;
   } req_type;

   // Result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
      status_type status;
   } rsp_type;

   // One classified job: a finished character or an error report
   typedef struct packed {
      logic        is_error;
      status_type  status;
      logic [20:0] code_point;
      logic        fin;
   } job_type;

   // Job handed from the front end into the queue
   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   localparam logic [20:0] CP_MAX    = 21'h10FFFF;
   localparam logic [20:0] SUPP_BASE = 21'h010000;
   localparam logic [15:0] HI_SURR   = 16'hD800;
   localparam logic [15:0] LO_SURR   = 16'hDC00;

endpackage

`default_nettype wire

[design/utu_front.sv]
// Front end: accepts UTF-8 bytes, tracks sequence state and classifies jobs.
`timescale 1ns / 1ps
`default_nettype none

module utu_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire utu_pkg::req_type  req_data,
   input  wire logic              queue_full,
   output utu_pkg::push_type      push
);

   logic [1:0]  pend_ff, pend_in;
   logic [20:0] acc_ff, acc_in;
   logic        err_ff, err_in;

   logic                req_fire;
   logic [7:0]          b;
   logic                fin;
   logic                fail;
   utu_pkg::status_type fail_status;
   logic                char_done;
   logic [20:0]         cp_done;
   logic [20:0]         acc_shift;

   assign req_ready = !queue_full;
   assign req_fire  = req_valid && req_ready;
   assign b         = req_data.in_byte;
   assign fin       = req_data.in_final;
   assign acc_shift = {acc_ff[14:0], b[5:0]};

   // Decode the byte against the current sequence state
   always_comb begin
      pend_in     = pend_ff;
      acc_in      = acc_ff;
      err_in      = err_ff;
      fail        = 1'b0;
      fail_status = utu_pkg::ST_OK;
      char_done   = 1'b0;
      cp_done     = '0;
      push        = '0;
      if (req_fire && !err_ff) begin
         if (pend_ff == 2'd0) begin
            case (b) inside
               8'b0???_????: begin
                  char_done = 1'b1;
                  cp_done   = {13'd0, b};
               end
               8'b110?_????: begin
                  acc_in  = {16'd0, b[4:0]};
                  pend_in = 2'd1;
               end
               8'b1110_????: begin
                  acc_in  = {17'd0, b[3:0]};
                  pend_in = 2'd2;
               end
               8'b1111_0???: begin
                  acc_in  = {18'd0, b[2:0]};
                  pend_in = 2'd3;
               end
               default: begin
                  fail        = 1'b1;
                  fail_status = utu_pkg::ST_BAD_LEAD;
               end
            endcase
            // a lead byte that is also final leaves the sequence unfinished
            if (!fail && !char_done && fin) begin
               fail        = 1'b1;
               fail_status = utu_pkg::ST_INCOMPLETE;
            end
         end else if (b[7:6] != 2'b10) begin
            fail        = 1'b1;
            fail_status = utu_pkg::ST_INCOMPLETE;
         end else begin
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               char_done = 1'b1;
               cp_done   = acc_shift;
               acc_in    = '0;
            end else begin
               acc_in = acc_shift;
               if (fin) begin
                  fail        = 1'b1;
                  fail_status = utu_pkg::ST_INCOMPLETE;
               end
            end
         end

         // out-of-range code point turns into an error
         if (char_done && (cp_done > utu_pkg::CP_MAX)) begin
            char_done   = 1'b0;
            fail        = 1'b1;
            fail_status = utu_pkg::ST_TOO_LARGE;
         end

         if (fail) begin
            pend_in              = '0;
            acc_in               = '0;
            err_in               = !fin;
            push.valid           = 1'b1;
            push.job.is_error    = 1'b1;
            push.job.status      = fail_status;
            push.job.code_point  = '0;
            push.job.fin         = 1'b1;
         end else if (char_done) begin
            push.valid           = 1'b1;
            push.job.is_error    = 1'b0;
            push.job.status      = utu_pkg::ST_OK;
            push.job.code_point  = cp_done;
            push.job.fin         = fin;
         end
      end
      // final byte returns everything to idle
      if (req_fire && fin) begin
         pend_in = '0;
         acc_in  = '0;
         err_in  = 1'b0;
      end
   end

   // Sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         acc_ff  <= '0;
         err_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         acc_ff  <= acc_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

[design/utu_queue.sv]
// Small job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module utu_queue #(
   parameter int ADDR_W = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire utu_pkg::push_type push,
   output logic                   full,
   input  wire logic              pop,
   output utu_pkg::head_type      head
);

   localparam int DEPTH = 1 << ADDR_W;

   utu_pkg::job_type  mem_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == (ADDR_W+1)'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

`default_nettype wire

[design/utu_back.sv]
// Back end: expands each job into UTF-16LE result words.
`timescale 1ns / 1ps
`default_nettype none

module utu_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire utu_pkg::head_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output utu_pkg::rsp_type       rsp_data
);

   logic                busy_ff, busy_in;
   logic [1:0]          idx_ff, idx_in;
   logic [1:0]          last_idx_ff, last_idx_in;
   logic [15:0]         unit0_ff, unit0_in;
   logic [15:0]         unit1_ff, unit1_in;
   logic                end_ff, end_in;
   utu_pkg::status_type status_ff, status_in;

   logic        rsp_fire;
   logic        at_last;
   logic [20:0] supp;

   assign rsp_valid = busy_ff;
   assign rsp_fire  = busy_ff && rsp_ready;
   assign at_last   = (idx_ff == last_idx_ff);
   assign pop       = head.valid && (!busy_ff || (rsp_fire && at_last));
   assign supp      = head.job.code_point - utu_pkg::SUPP_BASE;

   // Load a new job or step through the current one
   always_comb begin
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      unit0_in    = unit0_ff;
      unit1_in    = unit1_ff;
      end_in      = end_ff;
      status_in   = status_ff;
      if (pop) begin
         busy_in   = 1'b1;
         idx_in    = '0;
         end_in    = head.job.fin;
         status_in = head.job.status;
         if (head.job.is_error) begin
            last_idx_in = 2'd0;
            unit0_in    = '0;
            unit1_in    = '0;
         end else if (head.job.code_point[20:16] == '0) begin
            last_idx_in = 2'd1;
            unit0_in    = head.job.code_point[15:0];
            unit1_in    = '0;
         end else begin
            // surrogate pair, high unit first
            last_idx_in = 2'd3;
            unit0_in    = utu_pkg::HI_SURR | {6'd0, supp[19:10]};
            unit1_in    = utu_pkg::LO_SURR | {6'd0, supp[9:0]};
         end
      end else if (rsp_fire) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff <= last_idx_in;
      unit0_ff    <= unit0_in;
      unit1_ff    <= unit1_in;
      end_ff      <= end_in;
      status_ff   <= status_in;
   end

   // Result word, low byte of each unit first
   always_comb begin
      case (idx_ff)
         2'd0:    rsp_data.out_byte = unit0_ff[7:0];
         2'd1:    rsp_data.out_byte = unit0_ff[15:8];
         2'd2:    rsp_data.out_byte = unit1_ff[7:0];
         default: rsp_data.out_byte = unit1_ff[15:8];
      endcase
      rsp_data.run_last   = at_last;
      rsp_data.stream_end = at_last && end_ff;
      rsp_data.status     = status_ff;
   end

endmodule

`default_nettype wire

[design/utf8_to_utf16le_transcoder_core.sv]
// Top level of the UTF-8 to UTF-16LE transcoder.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    utu_pkg::req_type (in_byte, in_final)
//   rsp      out  rsp_valid/rsp_ready    utu_pkg::rsp_type (out_byte, run_last,
//                                        stream_end, status)
//
// The front end takes one input word per cycle while the job queue has room.
// The back end sends one result word per cycle while rsp_ready is high: 2 per
// character below U+10000, 4 per surrogate pair, 1 per error, so the output
// side sets the sustained rate. Jobs pass through the queue, then the back end.
// Synchronous active-high reset clears sequence state, queue and back end.
// A stalled rsp side fills the queue (2**QUEUE_ADDR_W jobs), then drops req_ready.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16le_transcoder_core #(
   parameter int QUEUE_ADDR_W = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire utu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output utu_pkg::rsp_type      rsp_data
);

   utu_pkg::push_type push;
   utu_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   utu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push)
   );

   utu_queue #(
      .ADDR_W (QUEUE_ADDR_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   utu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // End of string is always the last word of its job
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_end |-> rsp_data.run_last)
      else $error("stream_end without run_last");

   // Error words are single, closing and carry a zero byte
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != utu_pkg::ST_OK) |->
         rsp_data.run_last && rsp_data.stream_end && (rsp_data.out_byte == 8'd0))
      else $error("malformed error word");

   // Nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");
`endif

endmodule

`default_nettype wire

[test/utf8_to_utf16le_transcoder_core_test.sv]
// Self-checking testbench for the UTF-8 to UTF-16LE transcoder core.
`timescale 1ns / 1ps

module utf8_to_utf16le_transcoder_core_test;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 80;

   localparam logic [20:0] PLANE1_BASE = 21'h010000;
   localparam logic [20:0] UNICODE_MAX = 21'h10FFFF;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;

   typedef enum int {
      CH_ONE_BYTE,
      CH_TWO_BYTE,
      CH_THREE_BYTE,
      CH_SUPPLEMENTARY,
      CH_BEYOND_RANGE
   } char_kind_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   utu_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   utu_pkg::rsp_type rsp_data;

   // Decoder state mirrored from the block
   logic [1:0]  pend_count = 2'd0;
   logic [20:0] code_acc   = '0;
   logic        swallowing = 1'b0;

   utu_pkg::rsp_type expected_words[$];
   logic [7:0]       utf8_text[$];

   int error_count   = 0;
   int live_items    = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 73;
   int hold_ticket   = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   utf8_to_utf16le_transcoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 50 MHz clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Queue one expected result word
   function automatic void expect_word(logic [7:0] b, logic last, logic fin,
                                       utu_pkg::status_type st);
      utu_pkg::rsp_type w;
      w.out_byte   = b;
      w.run_last   = last;
      w.stream_end = fin;
      w.status     = st;
      expected_words.push_back(w);
   endfunction

   // Error word, then swallow everything up to the final byte
   function automatic void expect_error(utu_pkg::status_type st, logic fin);
      expect_word(8'h00, 1'b1, 1'b1, st);
      pend_count = 2'd0;
      code_acc   = '0;
      swallowing = !fin;
   endfunction

   // UTF-16LE bytes of one finished code point, low byte first
   function automatic void expect_code_point(logic [20:0] cp, logic fin);
      logic [20:0] offset;
      logic [15:0] high_unit;
      logic [15:0] low_unit;
      if (cp < PLANE1_BASE) begin
         expect_word(cp[7:0], 1'b0, 1'b0, utu_pkg::ST_OK);
         expect_word(cp[15:8], 1'b1, fin, utu_pkg::ST_OK);
      end else if (cp > UNICODE_MAX) begin
         expect_error(utu_pkg::ST_TOO_LARGE, fin);
      end else begin
         offset    = cp - PLANE1_BASE;
         high_unit = HIGH_SURR | {6'd0, offset[19:10]};
         low_unit  = LOW_SURR | {6'd0, offset[9:0]};
         expect_word(high_unit[7:0], 1'b0, 1'b0, utu_pkg::ST_OK);
         expect_word(high_unit[15:8], 1'b0, 1'b0, utu_pkg::ST_OK);
         expect_word(low_unit[7:0], 1'b0, 1'b0, utu_pkg::ST_OK);
         expect_word(low_unit[15:8], 1'b1, fin, utu_pkg::ST_OK);
      end
   endfunction

   // Advance the mirrored decoder by one input word
   function automatic void transcode_byte(utu_pkg::req_type w);
      logic [7:0]  b;
      logic        fin;
      logic [20:0] cp;
      b   = w.in_byte;
      fin = w.in_final;
      if (swallowing) begin
         // silent until the final byte clears the state below
      end else if (pend_count == 2'd0) begin
         if (!b[7]) begin
            expect_code_point({13'd0, b}, fin);
         end else if (b[7:5] == 3'b110) begin
            code_acc   = {16'd0, b[4:0]};
            pend_count = 2'd1;
            if (fin) expect_error(utu_pkg::ST_INCOMPLETE, fin);
         end else if (b[7:4] == 4'b1110) begin
            code_acc   = {17'd0, b[3:0]};
            pend_count = 2'd2;
            if (fin) expect_error(utu_pkg::ST_INCOMPLETE, fin);
         end else if (b[7:3] == 5'b11110) begin
            code_acc   = {18'd0, b[2:0]};
            pend_count = 2'd3;
            if (fin) expect_error(utu_pkg::ST_INCOMPLETE, fin);
         end else begin
            expect_error(utu_pkg::ST_BAD_LEAD, fin);
         end
      end else if (b[7:6] != 2'b10) begin
         // bad continuation is consumed, not reread as a lead
         expect_error(utu_pkg::ST_INCOMPLETE, fin);
      end else begin
         code_acc   = {code_acc[14:0], b[5:0]};
         pend_count = pend_count - 2'd1;
         if (pend_count == 2'd0) begin
            cp       = code_acc;
            code_acc = '0;
            expect_code_point(cp, fin);
         end else if (fin) begin
            expect_error(utu_pkg::ST_INCOMPLETE, fin);
         end
      end
      if (fin) begin
         pend_count = 2'd0;
         code_acc   = '0;
         swallowing = 1'b0;
      end
   endfunction

   // Predict on accepted input words, check accepted result words
   always @(posedge clock) begin : scoreboard
      utu_pkg::rsp_type want;
      if (reset) begin
         pend_count = 2'd0;
         code_acc   = '0;
         swallowing = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (!swallowing) live_items++;
            transcode_byte(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               error_count++;
               $error("unexpected result word: out_byte %02h status %0d",
                      rsp_data.out_byte, rsp_data.status);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  error_count++;
                  $error("out_byte: expected %02h, got %02h",
                         want.out_byte, rsp_data.out_byte);
               end
               if (rsp_data.run_last !== want.run_last) begin
                  error_count++;
                  $error("run_last: expected %0b, got %0b",
                         want.run_last, rsp_data.run_last);
               end
               if (rsp_data.stream_end !== want.stream_end) begin
                  error_count++;
                  $error("stream_end: expected %0b, got %0b",
                         want.stream_end, rsp_data.stream_end);
               end
               if (rsp_data.status !== want.status) begin
                  error_count++;
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               end
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_ticket) begin
         hold_seen <= hold_ticket;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("utf8_to_utf16le_transcoder_core_test: errors");
         $finish;
      end
   end

   // Offer one input word and hold it until accepted
   task automatic send_word(input logic [7:0] b, input logic fin);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, in_final: fin};
      do @(posedge clock); while (!req_ready);
   endtask

   // Send the staged text, final flag on its last byte
   task automatic send_text();
      for (int i = 0; i < utf8_text.size(); i++)
         send_word(utf8_text[i], i == utf8_text.size() - 1);
      utf8_text.delete();
   endtask

   // Sender pauses until every expected word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // Append the UTF-8 encoding of one random character
   task automatic append_char(input char_kind_type kind);
      logic [20:0] cp;
      case (kind)
         CH_ONE_BYTE: begin
            cp = 21'($urandom_range(127));
            utf8_text.push_back(cp[7:0]);
         end
         CH_TWO_BYTE: begin
            cp = 21'($urandom_range(21'h7FF));
            utf8_text.push_back({3'b110, cp[10:6]});
            utf8_text.push_back({2'b10, cp[5:0]});
         end
         CH_THREE_BYTE: begin
            cp = 21'($urandom_range(21'hFFFF));
            utf8_text.push_back({4'b1110, cp[15:12]});
            utf8_text.push_back({2'b10, cp[11:6]});
            utf8_text.push_back({2'b10, cp[5:0]});
         end
         default: begin
            if (kind == CH_SUPPLEMENTARY)
               cp = 21'($urandom_range(UNICODE_MAX, PLANE1_BASE));
            else
               cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
            utf8_text.push_back({5'b11110, cp[20:18]});
            utf8_text.push_back({2'b10, cp[17:12]});
            utf8_text.push_back({2'b10, cp[11:6]});
            utf8_text.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Damage the staged text: stray continuation or invalid byte, cut short, or a clobbered byte
   task automatic break_text();
      int pos;
      pos = int'($urandom_range(utf8_text.size() - 1));
      case ($urandom_range(2))
         0: begin
            if ($urandom_range(1))
               utf8_text.insert(pos, 8'($urandom_range(8'hBF, 8'h80)));
            else
               utf8_text.insert(pos, 8'($urandom_range(8'hFF, 8'hF8)));
         end
         1: begin
            while (utf8_text.size() > pos + 1) void'(utf8_text.pop_back());
         end
         default: utf8_text[pos] = 8'($urandom_range(255));
      endcase
   endtask

   // Field extremes and every error path
   task automatic test_directed();
      // lowest and highest ASCII
      utf8_text = '{8'h7F, 8'h00};
      send_text();
      // two- and three-byte characters, top of the BMP
      utf8_text = '{8'hC2, 8'hA9};
      send_text();
      utf8_text = '{8'hEF, 8'hBF, 8'hBF};
      send_text();
      // lowest and highest supplementary code points: surrogate pairs
      utf8_text = '{8'hF0, 8'h90, 8'h80, 8'h80};
      send_text();
      utf8_text = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text();
      // code point past U+10FFFF mid-string, tail swallowed
      utf8_text = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h41};
      send_text();
      // invalid lead: mid-string, then as the final byte
      utf8_text = '{8'hFF, 8'h20};
      send_text();
      utf8_text = '{8'h80};
      send_text();
      // final flag on an unfinished sequence
      utf8_text = '{8'hE2, 8'h82};
      send_text();
      // continuation without the 10 prefix, tail swallowed
      utf8_text = '{8'hC3, 8'h28, 8'h41};
      send_text();
   endtask

   // Mostly well-formed strings, some damaged, a few pure noise
   task automatic test_random_traffic(input int target);
      int start;
      int n_chars;
      int pick;
      start = live_items;
      while (live_items - start < target) begin
         if ($urandom_range(99) < 8) begin
            n_chars = $urandom_range(5, 1);
            repeat (n_chars) utf8_text.push_back(8'($urandom_range(255)));
         end else begin
            n_chars = $urandom_range(6, 1);
            repeat (n_chars) begin
               pick = $urandom_range(99);
               append_char(pick < 30 ? CH_ONE_BYTE :
                           pick < 50 ? CH_TWO_BYTE :
                           pick < 70 ? CH_THREE_BYTE :
                           pick < 92 ? CH_SUPPLEMENTARY : CH_BEYOND_RANGE);
            end
            if ($urandom_range(99) < 15) break_text();
         end
         send_text();
      end
   endtask

   // Long result hold-off while surrogate pairs keep coming: queue fills, input stalls
   task automatic test_output_stall();
      hold_ticket <= hold_ticket + 1;
      repeat (6) append_char(CH_SUPPLEMENTARY);
      repeat (4) append_char(CH_ONE_BYTE);
      send_text();
      wait_for_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      test_directed();
      test_random_traffic(90);
      wait_for_drain();

      // roles swapped
      send_idle_pct = 73;
      recv_idle_pct = 26;
      test_random_traffic(90);
      wait_for_drain();

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_output_stall();
      test_random_traffic(70);
      wait_for_drain();

      // catch any stray words after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("utf8_to_utf16le_transcoder_core_test: clean");
      else
         $display("utf8_to_utf16le_transcoder_core_test: errors");
      $finish;
   end

endmodule
